>>> design/rsa_pkg.sv
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared types and constants for the stack calculator: command codes,
// controller states and the command/status bundles between the two halves.
// ----------------------------------------------------------------------------
package rsa_pkg;

    localparam int WORD_W          = 32;
    localparam int DEPTH_W         = 11;
    localparam int CMD_W           = 3;
    localparam int STACK_DEPTH_DEF = 1024;
    localparam int DIV_CNT_W       = $clog2(WORD_W);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 3'd0,
        CMD_ADD  = 3'd1,
        CMD_SUB  = 3'd2,
        CMD_MUL  = 3'd3,
        CMD_DIV  = 3'd4
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_POP_B,
        S_POP_A,
        S_EXEC,
        S_DIV,
        S_DIV_END,
        S_REFILL,
        S_REFILL_WAIT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic push;
        logic pop_b;
        logic pop_a;
        logic exec;
        logic div_step;
        logic div_end;
        logic refill_ld;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_div;
        logic b_zero;
        logic div_last;
    } t_dp_sts;

endpackage

>>> design/rsa_ctrl.sv
// ----------------------------------------------------------------------------
// rsa_ctrl
// Sequencer for one request: decode, push or pops, execute, divide loop,
// top-of-stack refill and hand-off to the output register.
// ----------------------------------------------------------------------------
module rsa_ctrl
    import rsa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [CMD_W-1:0] i_command,
    input  logic             i_stall,
    input  t_dp_sts          i_sts,
    output logic             o_stall,
    output logic             o_valid,
    output t_dp_cmd          o_cmd
);

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    priority case (t_cmd'(i_command))
                        CMD_PUSH: n_state = S_PUSH;
                        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: n_state = S_POP_B;
                        default:  n_state = S_FINISH;
                    endcase
                end
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = S_FINISH;
            end
            S_POP_B: begin
                o_cmd.pop_b = 1'b1;
                n_state     = S_POP_A;
            end
            S_POP_A: begin
                o_cmd.pop_a = 1'b1;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (!i_sts.is_div) begin
                    n_state = S_FINISH;
                end else if (i_sts.b_zero) begin
                    n_state = S_REFILL;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_DIV_END;
                end
            end
            S_DIV_END: begin
                o_cmd.div_end = 1'b1;
                n_state       = S_FINISH;
            end
            S_REFILL: begin
                n_state = S_REFILL_WAIT;
            end
            S_REFILL_WAIT: begin
                o_cmd.refill_ld = 1'b1;
                n_state         = S_FINISH;
            end
            S_FINISH: begin
                if (!r_valid || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (o_cmd.out_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

>>> design/rsa_datapath.sv
// ----------------------------------------------------------------------------
// rsa_datapath
// Stack memory with a cached top entry, ALU, iterative divider, error flags
// and the output register.
// ----------------------------------------------------------------------------
module rsa_datapath
    import rsa_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic [CMD_W-1:0]         i_command,
    input  logic signed [WORD_W-1:0] i_value,
    output t_dp_sts                  o_sts,
    output logic signed [WORD_W-1:0] o_top_value,
    output logic [DEPTH_W-1:0]       o_depth,
    output logic                     o_overflow,
    output logic                     o_underflow,
    output logic                     o_divide_by_zero
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [WORD_W-1:0] mem [STACK_DEPTH];
    logic [WORD_W-1:0] r_rdata;

    logic [CW-1:0]     r_count;
    logic [WORD_W-1:0] r_top;
    logic [CMD_W-1:0]  r_op;
    logic [WORD_W-1:0] r_val;
    logic [WORD_W-1:0] r_a;
    logic [WORD_W-1:0] r_b;
    logic              r_ovf;
    logic              r_unf;
    logic              r_dz;

    logic [WORD_W-1:0]    r_rem;
    logic [WORD_W-1:0]    r_quo;
    logic [WORD_W-1:0]    r_dvs;
    logic [DIV_CNT_W-1:0] r_dcnt;
    logic                 r_neg;

    logic [CW-1:0]     cnt_m1;
    logic [CW-1:0]     cnt_m2;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [WORD_W-1:0] alu_res;
    logic [2*WORD_W-1:0] prod;
    logic [WORD_W-1:0] mag_a;
    logic [WORD_W-1:0] mag_b;
    logic [WORD_W+1:0] trial;
    logic [CW+DEPTH_W-1:0] depth_ext;

    assign cnt_m1  = r_count - CW'(1);
    assign cnt_m2  = r_count - CW'(2);
    assign rd_addr = i_cmd.pop_b ? cnt_m2[AW-1:0] : cnt_m1[AW-1:0];
    assign wr_en   = i_cmd.push && (r_count != CW'(STACK_DEPTH)) && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[cnt_m1[AW-1:0]] <= r_top;
        end
        r_rdata <= mem[rd_addr];
    end

    assign prod  = r_a * r_b;
    assign mag_a = r_a[WORD_W-1] ? (~r_a + WORD_W'(1)) : r_a;
    assign mag_b = r_b[WORD_W-1] ? (~r_b + WORD_W'(1)) : r_b;
    assign trial = {1'b0, r_rem, r_quo[WORD_W-1]} - {2'b00, r_dvs};

    always_comb begin
        priority case (t_cmd'(r_op))
            CMD_ADD: alu_res = r_a + r_b;
            CMD_SUB: alu_res = r_a - r_b;
            default: alu_res = prod[WORD_W-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.push && (r_count != CW'(STACK_DEPTH))) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.pop_a) begin
            r_count <= (r_count < CW'(2)) ? '0 : cnt_m2;
        end else if ((i_cmd.exec && (t_cmd'(r_op) != CMD_DIV)) || i_cmd.div_end) begin
            r_count <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_command;
            r_val <= i_value;
            r_ovf <= 1'b0;
            r_unf <= 1'b0;
            r_dz  <= 1'b0;
        end
        if (i_cmd.push) begin
            if (r_count == CW'(STACK_DEPTH)) begin
                r_ovf <= 1'b1;
            end else begin
                r_top <= r_val;
            end
        end
        if (i_cmd.pop_b) begin
            r_b <= (r_count != '0) ? r_top : '0;
        end
        if (i_cmd.pop_a) begin
            r_a   <= (r_count < CW'(2)) ? '0 : r_rdata;
            r_unf <= (r_count < CW'(2));
        end
        if (i_cmd.exec) begin
            if (t_cmd'(r_op) != CMD_DIV) begin
                r_top <= alu_res;
            end else if (r_b == '0) begin
                r_dz <= 1'b1;
            end else begin
                r_rem  <= '0;
                r_quo  <= mag_a;
                r_dvs  <= mag_b;
                r_dcnt <= '0;
                r_neg  <= r_a[WORD_W-1] ^ r_b[WORD_W-1];
            end
        end
        if (i_cmd.div_step) begin
            if (!trial[WORD_W+1]) begin
                r_rem <= trial[WORD_W-1:0];
                r_quo <= {r_quo[WORD_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[WORD_W-2:0], r_quo[WORD_W-1]};
                r_quo <= {r_quo[WORD_W-2:0], 1'b0};
            end
            r_dcnt <= r_dcnt + DIV_CNT_W'(1);
        end
        if (i_cmd.div_end) begin
            r_top <= r_neg ? (~r_quo + WORD_W'(1)) : r_quo;
        end
        if (i_cmd.refill_ld) begin
            r_top <= r_rdata;
        end
    end

    assign depth_ext = (CW+DEPTH_W)'(r_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_top_value      <= (r_count != '0) ? r_top : '0;
            o_depth          <= depth_ext[DEPTH_W-1:0];
            o_overflow       <= r_ovf;
            o_underflow      <= r_unf;
            o_divide_by_zero <= r_dz;
        end
    end

    assign o_sts.is_div   = (t_cmd'(r_op) == CMD_DIV);
    assign o_sts.b_zero   = (r_b == '0);
    assign o_sts.div_last = (r_dcnt == DIV_CNT_W'(WORD_W - 1));

endmodule

>>> design/rpn_stack_alu_unit.sv
// ----------------------------------------------------------------------------
// rpn_stack_alu_unit
// Data stack with a 32-bit signed ALU, one request at a time.
// ----------------------------------------------------------------------------
// Each request (push, add, subtract, multiply, divide) returns one result
// carrying the new top of stack, the depth and the overflow, underflow and
// divide-by-zero flags. One request is worked on at a time: a push writes
// the top entry, add, subtract and multiply pop both operands and execute, a
// divide then runs the 32-step restoring divider, a divide by zero refills
// the top from the stack memory and an unused command only returns a result.
// The input is ready again from the cycle the result appears, so a new
// request is not taken before the last one is through. The top entry lives in
// a register and the rest in a stack memory with one write port and one
// registered read port, so each pop below the top costs a registered memory
// read. The stack memory needs no clearing after reset. A finished result is
// held in the output register while the next request is taken.
// ----------------------------------------------------------------------------
module rpn_stack_alu_unit
    import rsa_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [CMD_W-1:0]         i_command,
    input  logic signed [WORD_W-1:0] i_value,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [WORD_W-1:0] o_top_value,
    output logic [DEPTH_W-1:0]       o_depth,
    output logic                     o_overflow,
    output logic                     o_underflow,
    output logic                     o_divide_by_zero
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    rsa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_stall   (i_stall),
        .i_sts     (dp_sts),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .o_cmd     (dp_cmd)
    );

    rsa_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .i_command        (i_command),
        .i_value          (i_value),
        .o_sts            (dp_sts),
        .o_top_value      (o_top_value),
        .o_depth          (o_depth),
        .o_overflow       (o_overflow),
        .o_underflow      (o_underflow),
        .o_divide_by_zero (o_divide_by_zero)
    );

endmodule
